[rtl/dsc_pkg.sv]
package dsc_pkg;

  // fixed field widths
  localparam int SYMBOL_W   = 8;
  localparam int OUT_W      = 32;
  localparam int PLEN_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // longest pattern the register map can describe
  localparam int PAT_LIMIT  = 16;
  localparam int PAT_BYTES_W = PAT_LIMIT * SYMBOL_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2
  } cfg_index_e;

  // per-symbol control broadcast to every cell
  typedef struct packed {
    logic                step;
    logic                first;
    logic [SYMBOL_W-1:0] symbol;
  } cell_ctrl_t;

  // programmed pattern
  typedef struct packed {
    logic [PLEN_W-1:0]      length;
    logic [PAT_BYTES_W-1:0] bytes;
  } pattern_t;

endpackage

[rtl/dsc_if.sv]
interface dsc_in_if import dsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                first;

  modport source (output valid, output symbol, output first, input ready);
  modport sink   (input valid, input symbol, input first, output ready);
endinterface

interface dsc_out_if import dsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] match_count;
  logic             saturated;

  modport source (output valid, output match_count, output saturated, input ready);
  modport sink   (input valid, input match_count, input saturated, output ready);
endinterface

interface dsc_cfg_if import dsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/dsc_cfg_regs.sv]
module dsc_cfg_regs import dsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsc_cfg_if.sink   cfg_i,
  output pattern_t  pattern_o
);

  logic [PLEN_W-1:0]     length_q, length_d;
  logic [CFG_DATA_W-1:0] low_q, low_d;
  logic [CFG_DATA_W-1:0] high_q, high_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register decode, unknown indexes dropped
  always_comb begin
    length_d = length_q;
    low_d    = low_q;
    high_d   = high_q;
    if (cfg_i.valid) begin
      case (cfg_index_e'(cfg_i.index))
        CFG_PATTERN_LENGTH: length_d = cfg_i.data[PLEN_W-1:0];
        CFG_PATTERN_LOW:    low_d    = cfg_i.data;
        CFG_PATTERN_HIGH:   high_d   = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
      low_q    <= '0;
      high_q   <= '0;
    end else begin
      length_q <= length_d;
      low_q    <= low_d;
      high_q   <= high_d;
    end
  end

  assign pattern_o.length = length_q;
  assign pattern_o.bytes  = {high_q, low_q};

endmodule

[rtl/dsc_cell.sv]
module dsc_cell import dsc_pkg::*; #(
  parameter int CountBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 active_i,
  input  logic [SYMBOL_W-1:0]  pat_byte_i,
  input  logic [CountBits-1:0] left_i,
  output logic [CountBits-1:0] count_o,
  output logic                 sat_o
);

  logic [CountBits-1:0] count_q, count_d;
  logic [CountBits-1:0] base;
  logic [CountBits-1:0] addend;
  logic [CountBits:0]   sum;
  logic                 hit;

  // saturating add of the left neighbour's old count on a match
  always_comb begin
    hit    = active_i && (pat_byte_i == ctrl_i.symbol);
    base   = ctrl_i.first ? '0 : count_q;
    addend = hit ? left_i : '0;
    sum    = {1'b0, base} + {1'b0, addend};
    sat_o  = ctrl_i.step && sum[CountBits];
  end

  // inactive cells hold unless a new text clears them
  always_comb begin
    count_d = count_q;
    if (ctrl_i.step) begin
      if (active_i) begin
        count_d = sum[CountBits] ? '1 : sum[CountBits-1:0];
      end else if (ctrl_i.first) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

[rtl/distinct_subsequence_counter.sv]
// Distinct subsequence counter. Text bytes arrive on req_i; for each one the
// block returns on rsp_o the number of distinct ways the programmed pattern
// (up to 16 bytes, and no longer than MaxPattern) occurs as a subsequence of
// the text so far, saturating at all ones with a sticky saturated flag, and
// 1 for an empty pattern. A request with first set starts a new text. One
// request is taken per clock unless a stalled response holds it off. The row
// of MaxPattern cells updates in parallel in the cycle a request is taken,
// and a combinational select of the last active cell drives the output
// register. Program the pattern only while no request is in flight; counts
// persist across a pattern change until the next first.
module distinct_subsequence_counter import dsc_pkg::*; #(
  parameter int MaxPattern = 16,
  parameter int CountBits  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsc_in_if.sink     req_i,
  dsc_out_if.source  rsp_o,
  dsc_cfg_if.sink    cfg_i
);

  localparam int LenLimit = (MaxPattern < PAT_LIMIT) ? MaxPattern : PAT_LIMIT;

  pattern_t             pattern;
  cell_ctrl_t           ctrl;
  logic [PLEN_W-1:0]    len;
  logic [CountBits-1:0] counts [MaxPattern];
  logic [MaxPattern-1:0] sat_vec;
  logic                 accept;
  logic                 stage_q, stage_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [CountBits-1:0] sel;
  logic [OUT_W-1:0]     clipped;
  logic [OUT_W-1:0]     count_out_q;
  logic                 sat_out_q;

  // configuration registers
  dsc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .pattern_o (pattern)
  );

  // active pattern length
  assign len = (pattern.length > PLEN_W'(LenLimit)) ? PLEN_W'(LenLimit) : pattern.length;

  // handshake
  assign out_load    = stage_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !stage_q || out_load;
  assign accept      = req_i.valid && req_i.ready;

  assign ctrl.step   = accept;
  assign ctrl.first  = req_i.first;
  assign ctrl.symbol = req_i.symbol;

  // row of prefix cells
  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    logic                 active;
    logic [SYMBOL_W-1:0]  pat_byte;
    logic [CountBits-1:0] left;

    if (j < PAT_LIMIT) begin : g_used
      assign active   = len > PLEN_W'(j);
      assign pat_byte = pattern.bytes[SYMBOL_W*j +: SYMBOL_W];
    end else begin : g_unused
      assign active   = 1'b0;
      assign pat_byte = '0;
    end

    if (j == 0) begin : g_head
      assign left = CountBits'(1);
    end else begin : g_link
      assign left = req_i.first ? '0 : counts[j-1];
    end

    dsc_cell #(
      .CountBits (CountBits)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .active_i   (active),
      .pat_byte_i (pat_byte),
      .left_i     (left),
      .count_o    (counts[j]),
      .sat_o      (sat_vec[j])
    );
  end

  // sticky overflow and stage tracking
  always_comb begin
    ovf_d = ovf_q;
    if (accept) begin
      ovf_d = (ovf_q && !req_i.first) || (|sat_vec);
    end
    stage_d = accept ? 1'b1 : (out_load ? 1'b0 : stage_q);
    out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      stage_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ovf_q       <= ovf_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  // select the full-pattern cell
  always_comb begin
    sel = (len == '0) ? CountBits'(1) : '0;
    for (int j = 0; j < LenLimit; j++) begin
      if (len == PLEN_W'(j + 1)) begin
        sel = counts[j];
      end
    end
  end

  // fit the count to the output width
  if (CountBits > OUT_W) begin : g_clip
    assign clipped = (|sel[CountBits-1:OUT_W]) ? '1 : sel[OUT_W-1:0];
  end else begin : g_extend
    assign clipped = OUT_W'(sel);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      count_out_q <= clipped;
      sat_out_q   <= ovf_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.match_count = count_out_q;
  assign rsp_o.saturated   = sat_out_q;

endmodule

[rtl/dsc_checker.sv]
module dsc_checker import dsc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [OUT_W-1:0]      rsp_count,
  input logic                  rsp_sat,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic empty_q;

  // track whether the programmed pattern is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index_e'(cfg_index) == CFG_PATTERN_LENGTH)) begin
      empty_q <= (cfg_data[PLEN_W-1:0] == '0);
    end
  end

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_sat))
    else $error("response changed while stalled");

  // a fresh response follows an accepted request
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without matching request");

  // requests are only held off by a stalled response
  a_req_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request stalled without output backpressure");

  // empty pattern always counts one
  a_empty_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && empty_q |-> rsp_count == OUT_W'(1))
    else $error("empty pattern count not one");

endmodule

bind distinct_subsequence_counter dsc_checker u_dsc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_count (rsp_o.match_count),
  .rsp_sat   (rsp_o.saturated),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready),
  .cfg_index (cfg_i.index),
  .cfg_data  (cfg_i.data)
);
